### hdl/tlen_pkg.sv
// Types and constants shared by the text line-ending normaliser.
// Word layouts, character codes and the controller-datapath command set.
// No dependencies.
`default_nettype none

package tlen_pkg;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_EOT  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_char;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_word_t;

  // Class of an incoming word against the current state.
  typedef enum logic [2:0] {
    CLS_EOT      = 3'd0,
    CLS_ABSORB   = 3'd1,
    CLS_LINE_END = 3'd2,
    CLS_BLANK    = 3'd3,
    CLS_ORD      = 3'd4
  } cls_t;

  // Datapath operation for one cycle.
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_EOT      = 3'd1,
    OP_ABSORB   = 3'd2,
    OP_LINE_END = 3'd3,
    OP_BLANK    = 3'd4,
    OP_STEP     = 3'd5
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_char;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic step_is_char;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### hdl/tlen_datapath.sv
// Datapath of the text line-ending normaliser: pending counts, flags,
// held character and the output register.
// Depends on tlen_pkg.
`default_nettype none

module tlen_datapath
  import tlen_pkg::*;
#(
  parameter int MAX_PENDING_SPACES   = 31,
  parameter int MAX_PENDING_NEWLINES = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_word_t  char_word,
  input  wire cmd_t      cmd,
  output sts_t           sts,
  output logic           text_valid,
  input  wire logic      text_ready,
  output out_word_t      text_word
);

  localparam int SpW = $clog2(MAX_PENDING_SPACES + 1);
  localparam int NlW = $clog2(MAX_PENDING_NEWLINES + 1);
  localparam logic [SpW-1:0] SpMax = SpW'(MAX_PENDING_SPACES);
  localparam logic [NlW-1:0] NlMax = NlW'(MAX_PENDING_NEWLINES);

  logic [NlW-1:0] pending_newlines;
  logic [SpW-1:0] pending_spaces;
  logic           after_cr;
  logic           emitted_any;
  logic [7:0]     held_char;
  logic [7:0]     step_char;
  logic [7:0]     ch;
  cls_t           cls;

  assign ch = char_word.data_char;

  always_comb begin
    priority if (char_word.command == CMD_EOT) begin
      cls = CLS_EOT;
    end else if (ch == CHAR_LF && after_cr) begin
      cls = CLS_ABSORB;
    end else if (ch == CHAR_CR || ch == CHAR_LF) begin
      cls = CLS_LINE_END;
    end else if (ch == CHAR_TAB || ch == CHAR_SPACE) begin
      cls = CLS_BLANK;
    end else begin
      cls = CLS_ORD;
    end
  end

  assign step_char        = cmd.load_char ? ch : held_char;
  assign sts.cls          = cls;
  assign sts.step_is_char = (pending_newlines == '0) && (pending_spaces == '0);
  assign sts.out_free     = !text_valid || text_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      held_char <= ch;
    end
    if (rst) begin
      pending_newlines <= '0;
      pending_spaces   <= '0;
      after_cr         <= 1'b0;
      emitted_any      <= 1'b0;
      text_valid       <= 1'b0;
    end else begin
      if (cmd.op == OP_STEP || (cmd.op == OP_EOT && emitted_any)) begin
        text_valid <= 1'b1;
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_NONE: begin
        end
        OP_EOT: begin
          if (emitted_any) begin
            text_word.out_char <= CHAR_LF;
            text_word.last     <= 1'b1;
          end
          pending_newlines <= '0;
          pending_spaces   <= '0;
          after_cr         <= 1'b0;
          emitted_any      <= 1'b0;
        end
        OP_ABSORB: begin
          after_cr <= 1'b0;
        end
        OP_LINE_END: begin
          after_cr       <= (ch == CHAR_CR);
          pending_spaces <= '0;
          if (pending_newlines < NlMax) begin
            pending_newlines <= pending_newlines + 1'b1;
          end
        end
        OP_BLANK: begin
          after_cr <= 1'b0;
          if (pending_spaces < SpMax) begin
            pending_spaces <= pending_spaces + 1'b1;
          end
        end
        OP_STEP: begin
          after_cr <= 1'b0;
          priority if (pending_newlines != '0) begin
            text_word.out_char <= CHAR_LF;
            text_word.last     <= 1'b0;
            pending_newlines   <= pending_newlines - 1'b1;
          end else if (pending_spaces != '0) begin
            text_word.out_char <= CHAR_SPACE;
            text_word.last     <= 1'b0;
            pending_spaces     <= pending_spaces - 1'b1;
          end else begin
            text_word.out_char <= step_char;
            text_word.last     <= 1'b1;
            emitted_any        <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/tlen_controller.sv
// Controller of the text line-ending normaliser: accepts input words and
// sequences the flush of pending newlines and spaces.
// Depends on tlen_pkg.
`default_nettype none

module tlen_controller
  import tlen_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic char_valid,
  output logic      char_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    char_ready    = 1'b0;
    cmd.op        = OP_NONE;
    cmd.load_char = 1'b0;
    state_next    = state;
    unique case (state)
      ST_IDLE: begin
        char_ready = sts.out_free;
        if (char_valid && sts.out_free) begin
          unique case (sts.cls)
            CLS_EOT:      cmd.op = OP_EOT;
            CLS_ABSORB:   cmd.op = OP_ABSORB;
            CLS_LINE_END: cmd.op = OP_LINE_END;
            CLS_BLANK:    cmd.op = OP_BLANK;
            CLS_ORD: begin
              cmd.op        = OP_STEP;
              cmd.load_char = 1'b1;
              if (!sts.step_is_char) begin
                state_next = ST_FLUSH;
              end
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      ST_FLUSH: begin
        // advance one pending character per free output slot
        if (sts.out_free) begin
          cmd.op = OP_STEP;
          if (sts.step_is_char) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/text_line_ending_normalizer.sv
// Top level of the text line-ending normaliser: controller and datapath.
// Depends on tlen_pkg, tlen_controller and tlen_datapath.
//
//   channel  | handshake               | word
//   ---------+-------------------------+---------------------------------
//   input    | char_valid / char_ready | char_word (command, data_char)
//   output   | text_valid / text_ready | text_word (out_char, last)
//
// An ordinary character behind n held newlines and m held spaces gives
// 1 + n + m words: the flush sequencer emits one word per cycle, while the
// output is free, from the single output register; no input is taken meanwhile.
// A stalled output holds the next word out; reset clears counts and flags.
`default_nettype none

module text_line_ending_normalizer
  import tlen_pkg::*;
#(
  parameter int MAX_PENDING_SPACES   = 31,
  parameter int MAX_PENDING_NEWLINES = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     char_valid,
  output logic          char_ready,
  input  wire in_word_t char_word,
  output logic          text_valid,
  input  wire logic     text_ready,
  output out_word_t     text_word
);

  cmd_t cmd;
  sts_t sts;

  tlen_controller u_controller (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tlen_datapath #(
    .MAX_PENDING_SPACES   (MAX_PENDING_SPACES),
    .MAX_PENDING_NEWLINES (MAX_PENDING_NEWLINES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .char_word  (char_word),
    .cmd        (cmd),
    .sts        (sts),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_word  (text_word)
  );

endmodule

`default_nettype wire

### tb/sv/tb_text_line_ending_normalizer.sv
// Testbench for text_line_ending_normalizer: a directed table, then random text
// streams, checked word by word against the table's expected words or a predictor of the normaliser.
// Depends on tlen_pkg and the normaliser RTL only.
`timescale 1ns / 100ps

module tb_text_line_ending_normalizer;
  import tlen_pkg::*;

  localparam int MAX_SPACES   = 31;
  localparam int MAX_NEWLINES = 32;
  localparam int RANDOM_ITEMS = 355;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    in_word_t   word;
    logic       typed;
    logic       exp_one;
    logic [7:0] exp_char;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    {CMD_EOT,  8'h00,      1'b1, 1'b0, 8'h00},
    {CMD_TEXT, 8'h41,      1'b1, 1'b1, 8'h41},
    {CMD_TEXT, 8'h00,      1'b1, 1'b1, 8'h00},
    {CMD_TEXT, 8'hFF,      1'b1, 1'b1, 8'hFF},
    {CMD_TEXT, CHAR_SPACE, 1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_TAB,   1'b0, 1'b0, 8'h00},
    {CMD_TEXT, 8'h62,      1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_SPACE, 1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_CR,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_LF,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, 8'h63,      1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_LF,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_LF,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_CR,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_CR,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, 8'h64,      1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_CR,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, 8'h65,      1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_LF,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_SPACE, 1'b0, 1'b0, 8'h00},
    {CMD_EOT,  8'hFF,      1'b1, 1'b1, CHAR_LF},
    {CMD_TEXT, CHAR_LF,    1'b0, 1'b0, 8'h00},
    {CMD_TEXT, CHAR_TAB,   1'b0, 1'b0, 8'h00},
    {CMD_TEXT, 8'h66,      1'b0, 1'b0, 8'h00},
    {CMD_EOT,  8'h5A,      1'b1, 1'b1, CHAR_LF}
  };

  logic      clk;
  logic      rst;
  logic      char_valid;
  logic      char_ready;
  in_word_t  char_word;
  logic      text_valid;
  logic      text_ready;
  out_word_t text_word;

  stim_row_t text_stream[$];
  out_word_t awaited_text[$];
  out_word_t step_words[$];

  logic [5:0] held_newlines;
  logic [4:0] held_spaces;
  logic       after_cr;
  logic       seen_output;

  int  words_taken;
  bit  took_char;
  int  fail_count;
  int  cycles;

  text_line_ending_normalizer #(
    .MAX_PENDING_SPACES  (MAX_SPACES),
    .MAX_PENDING_NEWLINES(MAX_NEWLINES)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .char_word (char_word),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text_word (text_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: %s mismatch, got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic emit_char(input logic [7:0] c);
    out_word_t w;
    w.out_char = c;
    w.last     = 1'b0;
    step_words.push_back(w);
  endtask

  // Fill step_words with what one accepted word gives, and advance the held state.
  task automatic normalize_word(input in_word_t w);
    int n;
    step_words.delete();
    if (w.command == CMD_EOT) begin
      if (seen_output)
        emit_char(CHAR_LF);
      held_newlines = '0;
      held_spaces   = '0;
      after_cr      = 1'b0;
      seen_output   = 1'b0;
    end else if (w.data_char == CHAR_LF && after_cr) begin
      after_cr = 1'b0;
    end else if (w.data_char == CHAR_CR || w.data_char == CHAR_LF) begin
      after_cr    = (w.data_char == CHAR_CR);
      held_spaces = '0;
      if (held_newlines < MAX_NEWLINES)
        held_newlines++;
    end else if (w.data_char == CHAR_TAB || w.data_char == CHAR_SPACE) begin
      after_cr = 1'b0;
      if (held_spaces < MAX_SPACES)
        held_spaces++;
    end else begin
      after_cr = 1'b0;
      repeat (held_newlines) emit_char(CHAR_LF);
      repeat (held_spaces) emit_char(CHAR_SPACE);
      emit_char(w.data_char);
      held_newlines = '0;
      held_spaces   = '0;
      seen_output   = 1'b1;
    end
    n = step_words.size();
    if (n > 0)
      step_words[n - 1].last = 1'b1;
  endtask

  function automatic logic [7:0] pick_ordinary();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) == 0)
        c = 8'($urandom_range(0, 255));
      else
        c = 8'($urandom_range(8'h21, 8'h7E));
    end while (c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR || c == CHAR_SPACE);
    return c;
  endfunction

  task automatic add_item(input logic cmd, input logic [7:0] c);
    stim_row_t r;
    r.word.command   = cmd;
    r.word.data_char = c;
    r.typed          = 1'b0;
    r.exp_one        = 1'b0;
    r.exp_char       = 8'h00;
    text_stream.push_back(r);
  endtask

  task automatic add_saturating_run();
    repeat ($urandom_range(33, 40)) add_item(CMD_TEXT, CHAR_LF);
    repeat ($urandom_range(32, 40))
      add_item(CMD_TEXT, $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
    add_item(CMD_TEXT, pick_ordinary());
  endtask

  // Accept words in, predict, and check words out.
  always @(posedge clk) begin
    took_char = 1'b0;
    if (!rst) begin
      if (char_valid && char_ready) begin
        normalize_word(char_word);
        if (text_stream[words_taken].typed) begin
          if (text_stream[words_taken].exp_one)
            awaited_text.push_back({text_stream[words_taken].exp_char, 1'b1});
        end else begin
          foreach (step_words[i]) awaited_text.push_back(step_words[i]);
        end
        words_taken++;
        took_char = 1'b1;
      end
      if (text_valid && text_ready) begin
        if (awaited_text.size() == 0) begin
          report_mismatch("unexpected word", text_word, 0);
        end else begin
          if (text_word.out_char !== awaited_text[0].out_char)
            report_mismatch("out_char", text_word.out_char, awaited_text[0].out_char);
          if (text_word.last !== awaited_text[0].last)
            report_mismatch("last", text_word.last, awaited_text[0].last);
          void'(awaited_text.pop_front());
        end
      end
    end
  end

  // Sender: bursts of random length with random gaps.
  initial begin
    int gap_left;
    int burst_left;
    logic offer;
    gap_left   = 0;
    burst_left = 0;
    char_valid = 1'b0;
    char_word  = '0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!(char_valid && !took_char)) begin
        if (words_taken >= text_stream.size()) begin
          char_valid <= 1'b0;
          break;
        end
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 30);
        end
        if (gap_left > 0) begin
          gap_left--;
          offer = 1'b0;
        end else begin
          burst_left--;
          offer = 1'b1;
        end
        char_valid <= offer;
        if (offer)
          char_word <= text_stream[words_taken].word;
      end
    end
  end

  // Receiver: stall patterns that change every so often, plus one long hold-off.
  initial begin
    rx_mode_t mode;
    int mode_left;
    int hold_left;
    int cyc;
    bit held_once;
    logic rdy;
    mode       = RX_OPEN;
    mode_left  = 0;
    hold_left  = 0;
    cyc        = 0;
    held_once  = 1'b0;
    text_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held_once && words_taken >= DIRECTED_ROWS + 60) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
        rdy       = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:     rdy = 1'b1;
          RX_COIN:     rdy = 1'($urandom_range(0, 1));
          RX_PERIODIC: rdy = (cyc % 5) != 0;
          default:     rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      text_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Build the stream, then wait for it to drain and give the verdict.
  initial begin
    int r;
    held_newlines = '0;
    held_spaces   = '0;
    after_cr      = 1'b0;
    seen_output   = 1'b0;
    words_taken   = 0;
    fail_count    = 0;
    cycles        = 0;
    took_char     = 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++)
      text_stream.push_back(DIRECTED[i]);
    add_saturating_run();
    while (text_stream.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        repeat ($urandom_range(1, 8)) add_item(CMD_TEXT, pick_ordinary());
      end else if (r < 58) begin
        repeat ($urandom_range(1, 4))
          add_item(CMD_TEXT, $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      end else if (r < 74) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0: add_item(CMD_TEXT, CHAR_CR);
            1: add_item(CMD_TEXT, CHAR_LF);
            default: begin
              add_item(CMD_TEXT, CHAR_CR);
              add_item(CMD_TEXT, CHAR_LF);
            end
          endcase
        end
      end else if (r < 78) begin
        if ($urandom_range(0, 2) == 0) begin
          add_saturating_run();
        end else begin
          repeat ($urandom_range(25, 40))
            add_item(CMD_TEXT, $urandom_range(0, 1) ? CHAR_SPACE : CHAR_LF);
          add_item(CMD_TEXT, pick_ordinary());
        end
      end else if (r < 84) begin
        add_item(CMD_EOT, 8'($urandom_range(0, 255)));
      end else if (r < 92) begin
        repeat ($urandom_range(1, 4)) add_item(CMD_TEXT, 8'($urandom_range(0, 255)));
      end else begin
        add_item(CMD_TEXT, CHAR_CR);
        add_item(CMD_TEXT, $urandom_range(0, 1) ? CHAR_TAB : pick_ordinary());
        add_item(CMD_TEXT, CHAR_LF);
      end
    end
    add_item(CMD_EOT, 8'($urandom_range(0, 255)));
    do @(posedge clk);
    while (words_taken < text_stream.size() || awaited_text.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### text_line_ending_normalizer.f
hdl/tlen_pkg.sv
hdl/tlen_datapath.sv
hdl/tlen_controller.sv
hdl/text_line_ending_normalizer.sv
tb/sv/tb_text_line_ending_normalizer.sv
